>>> hdl/nbfp_pkg.sv
// Shared constants for the n-bit field packer: register indexes, reset values, limits and field widths.
`default_nettype none
package nbfp_pkg;

  // Configuration register indexes
  localparam logic [1:0] CfgPrecision   = 2'd0;
  localparam logic [1:0] CfgBitOffset   = 2'd1;
  localparam logic [1:0] CfgElementSize = 2'd2;
  localparam logic [1:0] CfgByteOrder   = 2'd3;

  // Register reset values
  localparam logic [6:0] PrecisionReset   = 7'd8;
  localparam logic [5:0] BitOffsetReset   = 6'd0;
  localparam logic [3:0] ElementSizeReset = 4'd1;
  localparam logic       ByteOrderReset   = 1'b0;

  // Element size and precision limits
  localparam logic [3:0] MaxElementBytes = 4'd8;
  localparam logic [6:0] MaxPrecision    = 7'd64;

  // Field widths
  localparam int unsigned ElemW   = 64;
  localparam int unsigned StreamW = 72;

endpackage : nbfp_pkg
`default_nettype wire

>>> hdl/nbit_field_packer.sv
// Top level of the n-bit field packer: field extraction, bit stream packing, byte drain.
// With the drain register free, an accepted element is held in the input register and then
//   loaded into the drain register, whose top byte is presented as the first packed byte.
// Throughput: one packed byte per cycle on the output register while out_stall_i is low;
//   an element yields up to nine bytes, and the next element loads as its last byte is taken.
// An element that yields no byte only updates the leftover bits.
// Reset: registers return to 8, 0, 1, 0; leftover bits and all valid flags clear.
`default_nettype none
module nbit_field_packer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write port
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [6:0]  cfg_data_i,
  // input channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [63:0] element_bytes_i,
  input  wire logic        last_element_i,
  // output channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       packed_byte_o,
  output logic             last_o
);

  // configuration registers
  logic [6:0] precision_q;
  logic [5:0] bit_offset_q;
  logic [3:0] elem_size_q;
  logic       byte_order_q;

  // input register
  logic        in_valid_q, in_valid_d;
  logic [63:0] raw_q;
  logic        last_in_q;

  // leftover stream bits
  logic [6:0] pend_bits_q, pend_bits_d;
  logic [2:0] pend_cnt_q, pend_cnt_d;

  // drain register
  logic [nbfp_pkg::StreamW-1:0] stream_q, stream_d;
  logic [3:0]                   drain_cnt_q, drain_cnt_d;
  logic                         drain_last_q, drain_last_d;

  // datapath signals
  logic [3:0]                   size;
  logic [3:0]                   src;
  logic [nbfp_pkg::ElemW-1:0]   elem;
  logic [6:0]                   prec;
  logic [nbfp_pkg::ElemW-1:0]   shifted;
  logic [nbfp_pkg::ElemW-1:0]   mask;
  logic [nbfp_pkg::ElemW-1:0]   field;
  logic [nbfp_pkg::ElemW-1:0]   field_left;
  logic [7:0]                   pend_left;
  logic [nbfp_pkg::StreamW-1:0] stream;
  logic [nbfp_pkg::StreamW-1:0] tail;
  logic [6:0]                   total;
  logic [3:0]                   nfull;
  logic [2:0]                   rem;
  logic [3:0]                   nbytes;
  logic [7:0]                   tail_top;

  logic in_accept;
  logic out_accept;
  logic load;

  // write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      precision_q  <= nbfp_pkg::PrecisionReset;
      bit_offset_q <= nbfp_pkg::BitOffsetReset;
      elem_size_q  <= nbfp_pkg::ElementSizeReset;
      byte_order_q <= nbfp_pkg::ByteOrderReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        nbfp_pkg::CfgPrecision:   precision_q  <= cfg_data_i;
        nbfp_pkg::CfgBitOffset:   bit_offset_q <= cfg_data_i[5:0];
        nbfp_pkg::CfgElementSize: elem_size_q  <= cfg_data_i[3:0];
        nbfp_pkg::CfgByteOrder:   byte_order_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // handshakes
  assign out_accept = out_valid_o && !out_stall_i;
  assign load       = in_valid_q &&
                      ((drain_cnt_q == 4'd0) || ((drain_cnt_q == 4'd1) && out_accept));
  assign in_stall_o = in_valid_q && !load;
  assign in_accept  = in_valid_i && !in_stall_o;

  // assemble the element from its memory bytes
  always_comb begin
    size = (elem_size_q > nbfp_pkg::MaxElementBytes) ? nbfp_pkg::MaxElementBytes
                                                     : elem_size_q;
    elem = '0;
    src  = '0;
    for (int p = 0; p < 8; p++) begin
      src = byte_order_q ? (size - 4'd1 - 4'(p)) : 4'(p);
      if (4'(p) < size) begin
        elem[8*p +: 8] = raw_q[8*src[2:0] +: 8];
      end
    end
  end

  // cut the field and append it behind the leftover bits
  always_comb begin
    prec       = (precision_q > nbfp_pkg::MaxPrecision) ? nbfp_pkg::MaxPrecision
                                                        : precision_q;
    shifted    = elem >> bit_offset_q;
    mask       = (prec == nbfp_pkg::MaxPrecision) ? {nbfp_pkg::ElemW{1'b1}}
                                                  : ((64'd1 << prec) - 64'd1);
    field      = shifted & mask;
    field_left = (prec == 7'd0) ? '0 : (field << (nbfp_pkg::MaxPrecision - prec));
    pend_left  = {1'b0, pend_bits_q} << (4'd8 - {1'b0, pend_cnt_q});
    stream     = {pend_left, 64'd0} | ({field_left, 8'd0} >> pend_cnt_q);
    total      = {4'd0, pend_cnt_q} + prec;
    nfull      = total[6:3];
    rem        = total[2:0];
    nbytes     = nfull + {3'd0, (last_in_q && (rem != 3'd0))};
    tail       = stream << {nfull, 3'b000};
    tail_top   = tail[nbfp_pkg::StreamW-1 -: 8] >> (4'd8 - {1'b0, rem});
  end

  // next state of leftover bits, input register and drain register
  always_comb begin
    pend_bits_d  = pend_bits_q;
    pend_cnt_d   = pend_cnt_q;
    in_valid_d   = in_valid_q;
    stream_d     = stream_q;
    drain_cnt_d  = drain_cnt_q;
    drain_last_d = drain_last_q;
    if (load) begin
      in_valid_d   = 1'b0;
      stream_d     = stream;
      drain_cnt_d  = nbytes;
      drain_last_d = last_in_q;
      if (last_in_q) begin
        pend_bits_d = '0;
        pend_cnt_d  = '0;
      end else begin
        pend_bits_d = tail_top[6:0];
        pend_cnt_d  = rem;
      end
    end else if (out_accept) begin
      stream_d    = stream_q << 8;
      drain_cnt_d = drain_cnt_q - 4'd1;
    end
    if (in_accept) begin
      in_valid_d = 1'b1;
    end
  end

  // hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      pend_bits_q  <= '0;
      pend_cnt_q   <= '0;
      drain_cnt_q  <= '0;
      drain_last_q <= 1'b0;
    end else begin
      in_valid_q   <= in_valid_d;
      pend_bits_q  <= pend_bits_d;
      pend_cnt_q   <= pend_cnt_d;
      drain_cnt_q  <= drain_cnt_d;
      drain_last_q <= drain_last_d;
    end
  end

  // capture payload beats and update the drain register
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      raw_q     <= element_bytes_i;
      last_in_q <= last_element_i;
    end
    stream_q <= stream_d;
  end

  // drive the output beat from the top of the drain register
  assign out_valid_o   = (drain_cnt_q != 4'd0);
  assign packed_byte_o = stream_q[nbfp_pkg::StreamW-1 -: 8];
  assign last_o        = drain_last_q && (drain_cnt_q == 4'd1);

endmodule : nbit_field_packer
`default_nettype wire
